// ===== sv/gaps_pkg.sv =====
package gaps_pkg;

   localparam int MAX_ROWS  = 32;
   localparam int MAX_COLS  = 32;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int COORD_W   = 5;
   localparam int NODE_W    = 10;
   localparam int COST_W    = 11;
   localparam int LEN_W     = 11;
   localparam int DIM_W     = 6;
   localparam int H_W       = COORD_W + 1;
   // Every cell is closed at most once and pushes at most four entries.
   localparam int SEQ_W     = $clog2(4 * CELLS + 2);
   localparam int CSR_IDX_W = 2;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 2'd0,
      CSR_GRID_COLS = 2'd1
   } csr_code_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef struct packed {
      logic [COST_W-1:0] f;
      logic [COST_W-1:0] g;
      logic [NODE_W-1:0] node;
      logic [SEQ_W-1:0]  seq;
   } heap_entry_type;

   typedef struct packed {
      logic              closed;
      logic [COST_W-1:0] best;
   } cell_rec_type;

   typedef enum logic [4:0] {
      ST_INIT_MAP, ST_IDLE, ST_READ, ST_WAIT, ST_SEARCH, ST_CLEAR, ST_SEED,
      ST_POP_A, ST_POP_B, ST_POP_C, ST_SD_L, ST_SD_R, ST_SD_CMP,
      ST_EVAL, ST_EV_CHK, ST_NB_A, ST_NB_B, ST_PUSH, ST_SU_A, ST_SU_B,
      ST_NB_NEXT, ST_PATH, ST_PT_A, ST_PT_B
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_MAP_CLEAR, CMD_ACCEPT, CMD_READ_DONE, CMD_SEARCH,
      CMD_REC_CLEAR, CMD_SEED, CMD_POP_READ, CMD_POP_TAKE, CMD_POP_LAST,
      CMD_SD_LEFT, CMD_SD_RIGHT, CMD_SD_CMP, CMD_EVAL, CMD_CLOSE,
      CMD_NB_READ, CMD_NB_RELAX, CMD_PUSH, CMD_SU_READ, CMD_SU_CMP,
      CMD_NB_NEXT, CMD_PATH_START, CMD_PT_READ, CMD_PT_STEP
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       sweep_last;
      logic       search_oob;
      logic       search_trivial;
      logic       heap_empty;
      logic       pop_last;
      logic       sd_leaf;
      logic       sd_stop;
      logic       cur_is_goal;
      logic       cur_closed;
      logic       nb_out;
      logic       nb_skip;
      logic       heap_full;
      logic       su_root;
      logic       su_stop;
      logic       dir_last;
      logic       path_over;
      logic       path_end;
   } status_type;

   function automatic logic heap_less(input heap_entry_type a, input heap_entry_type b);
      return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
   endfunction

   function automatic logic [H_W-1:0] manhattan(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c,
                                                input logic [COORD_W-1:0] gr,
                                                input logic [COORD_W-1:0] gc);
      logic [COORD_W-1:0] dr;
      logic [COORD_W-1:0] dc;
      dr = (r > gr) ? r - gr : gr - r;
      dc = (c > gc) ? c - gc : gc - c;
      return H_W'(dr) + H_W'(dc);
   endfunction

endpackage

// ===== sv/gaps_if.sv =====
interface gaps_req_if;
   import gaps_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [COORD_W-1:0] cell_row;
   logic [COORD_W-1:0] cell_col;
   logic               blocked;
   logic [COORD_W-1:0] start_row;
   logic [COORD_W-1:0] start_col;
   logic [COORD_W-1:0] goal_row;
   logic [COORD_W-1:0] goal_col;
   logic [NODE_W-1:0]  path_index;
   modport source(output valid, req_type, cell_row, cell_col, blocked, start_row,
                  start_col, goal_row, goal_col, path_index, input ready);
   modport sink(input valid, req_type, cell_row, cell_col, blocked, start_row,
                start_col, goal_row, goal_col, path_index, output ready);
endinterface

interface gaps_rsp_if;
   import gaps_pkg::*;
   logic               valid;
   logic               ready;
   logic               found;
   logic [LEN_W-1:0]   path_length;
   logic [COORD_W-1:0] path_row;
   logic [COORD_W-1:0] path_col;
   logic               index_valid;
   modport source(output valid, found, path_length, path_row, path_col, index_valid,
                  input ready);
   modport sink(input valid, found, path_length, path_row, path_col, index_valid,
                output ready);
endinterface

interface gaps_csr_if;
   import gaps_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/gaps_ctrl.sv =====
module gaps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   input  gaps_pkg::status_type status,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output gaps_pkg::cmd_type    cmd
);
   import gaps_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_MAP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT_MAP: begin
            cmd = CMD_MAP_CLEAR;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_ACCEPT;
               case (status.req_kind)
                  REQ_SEARCH: state_in = ST_SEARCH;
                  REQ_READ:   state_in = ST_READ;
                  default:    state_in = ST_WAIT;
               endcase
            end
         end
         ST_READ: begin
            cmd      = CMD_READ_DONE;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            cmd = CMD_SEARCH;
            if (status.search_oob || status.search_trivial) state_in = ST_WAIT;
            else state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd = CMD_REC_CLEAR;
            if (status.sweep_last) state_in = ST_SEED;
         end
         ST_SEED: begin
            cmd      = CMD_SEED;
            state_in = ST_POP_A;
         end
         ST_POP_A: begin
            if (status.heap_empty) begin
               state_in = ST_WAIT;
            end else begin
               cmd      = CMD_POP_READ;
               state_in = ST_POP_B;
            end
         end
         ST_POP_B: begin
            cmd      = CMD_POP_TAKE;
            state_in = status.pop_last ? ST_EVAL : ST_POP_C;
         end
         ST_POP_C: begin
            cmd      = CMD_POP_LAST;
            state_in = ST_SD_L;
         end
         ST_SD_L: begin
            cmd      = CMD_SD_LEFT;
            state_in = status.sd_leaf ? ST_EVAL : ST_SD_R;
         end
         ST_SD_R: begin
            cmd      = CMD_SD_RIGHT;
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            cmd      = CMD_SD_CMP;
            state_in = status.sd_stop ? ST_EVAL : ST_SD_L;
         end
         ST_EVAL: begin
            cmd      = CMD_EVAL;
            state_in = status.cur_is_goal ? ST_PATH : ST_EV_CHK;
         end
         ST_EV_CHK: begin
            cmd      = CMD_CLOSE;
            state_in = status.cur_closed ? ST_POP_A : ST_NB_A;
         end
         ST_NB_A: begin
            cmd      = CMD_NB_READ;
            state_in = status.nb_out ? ST_NB_NEXT : ST_NB_B;
         end
         ST_NB_B: begin
            cmd      = CMD_NB_RELAX;
            state_in = status.nb_skip ? ST_NB_NEXT : ST_PUSH;
         end
         ST_PUSH: begin
            cmd      = CMD_PUSH;
            state_in = status.heap_full ? ST_WAIT : ST_SU_A;
         end
         ST_SU_A: begin
            cmd      = CMD_SU_READ;
            state_in = status.su_root ? ST_NB_NEXT : ST_SU_B;
         end
         ST_SU_B: begin
            cmd      = CMD_SU_CMP;
            state_in = status.su_stop ? ST_NB_NEXT : ST_SU_A;
         end
         ST_NB_NEXT: begin
            cmd      = CMD_NB_NEXT;
            state_in = status.dir_last ? ST_POP_A : ST_NB_A;
         end
         ST_PATH: begin
            cmd      = CMD_PATH_START;
            state_in = ST_PT_A;
         end
         ST_PT_A: begin
            if (status.path_over) begin
               state_in = ST_WAIT;
            end else begin
               cmd      = CMD_PT_READ;
               state_in = ST_PT_B;
            end
         end
         ST_PT_B: begin
            cmd      = CMD_PT_STEP;
            state_in = status.path_end ? ST_WAIT : ST_PT_A;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/gaps_dpath.sv =====
module gaps_dpath #(
   parameter int OPEN_DEPTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gaps_pkg::cmd_type                  cmd,
   output gaps_pkg::status_type               status,
   input  logic [1:0]                         req_type,
   input  logic [gaps_pkg::COORD_W-1:0]       cell_row,
   input  logic [gaps_pkg::COORD_W-1:0]       cell_col,
   input  logic                               blocked,
   input  logic [gaps_pkg::COORD_W-1:0]       start_row,
   input  logic [gaps_pkg::COORD_W-1:0]       start_col,
   input  logic [gaps_pkg::COORD_W-1:0]       goal_row,
   input  logic [gaps_pkg::COORD_W-1:0]       goal_col,
   input  logic [gaps_pkg::NODE_W-1:0]        path_index,
   input  logic                               csr_valid,
   input  logic [gaps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gaps_pkg::DIM_W-1:0]         csr_data,
   output logic                               found,
   output logic [gaps_pkg::LEN_W-1:0]         path_length,
   output logic [gaps_pkg::COORD_W-1:0]       path_row,
   output logic [gaps_pkg::COORD_W-1:0]       path_col,
   output logic                               index_valid
);
   import gaps_pkg::*;

   localparam int HIDX_W = $clog2(OPEN_DEPTH);
   localparam int HCNT_W = $clog2(OPEN_DEPTH + 1);
   localparam int HX_W   = HIDX_W + 1;

   // Memories.
   logic           obs_mem   [CELLS];
   cell_rec_type   rec_mem   [CELLS];
   logic [NODE_W-1:0] par_mem   [CELLS];
   logic [NODE_W-1:0] rpath_mem [CELLS];
   heap_entry_type heap_mem  [OPEN_DEPTH];

   logic              obs_we,   obs_wd,  obs_q;
   logic [NODE_W-1:0] obs_wa,   obs_ra;
   logic              rec_we;
   logic [NODE_W-1:0] rec_wa,   rec_ra;
   cell_rec_type      rec_wd,   rec_q;
   logic              par_we;
   logic [NODE_W-1:0] par_wa,   par_ra, par_wd, par_q;
   logic              rpath_we;
   logic [NODE_W-1:0] rpath_wa, rpath_ra, rpath_wd, rpath_q;
   logic              heap_we;
   logic [HIDX_W-1:0] heap_wa,  heap_ra;
   heap_entry_type    heap_wd,  heap_q;

   // Registers.
   logic [DIM_W-1:0]   rows_ff, rows_in, cols_ff, cols_in;
   logic [COORD_W-1:0] sr_ff, sr_in, sc_ff, sc_in, gr_ff, gr_in, gc_ff, gc_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               found_ff, found_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [HCNT_W-1:0]  count_ff, count_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [NODE_W-1:0]  sweep_ff, sweep_in;
   logic [HIDX_W-1:0]  i_ff, i_in;
   heap_entry_type     mov_ff, mov_in, left_ff, left_in;
   logic               has_r_ff, has_r_in;
   logic [COST_W-1:0]  cur_g_ff, cur_g_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   dir_type            dir_ff, dir_in;
   logic [LEN_W-1:0]   n_ff, n_in;
   logic [NODE_W-1:0]  walk_ff, walk_in;
   logic [COORD_W-1:0] prow_ff, prow_in, pcol_ff, pcol_in;
   logic               pval_ff, pval_in;

   // Derived values.
   logic [DIM_W-1:0]   rows_use, cols_use;
   logic [NODE_W-1:0]  start_cell, goal_cell, nb_node;
   logic [COORD_W-1:0] cur_r, cur_c, nb_r, nb_c;
   logic               nb_out;
   logic [COST_W-1:0]  ng;
   heap_entry_type     new_entry, seed_entry, sd_best;
   logic [HX_W-1:0]    l_idx, r_idx, cnt_x;
   logic [HIDX_W-1:0]  sd_pick, par_idx;
   logic               sd_stop;
   logic [LEN_W-1:0]   rd_addr;

   always_ff @(posedge clock) begin
      if (obs_we) obs_mem[obs_wa] <= obs_wd;
      obs_q <= obs_mem[obs_ra];
   end

   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[rec_wa] <= rec_wd;
      rec_q <= rec_mem[rec_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_q <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (rpath_we) rpath_mem[rpath_wa] <= rpath_wd;
      rpath_q <= rpath_mem[rpath_ra];
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_wa] <= heap_wd;
      heap_q <= heap_mem[heap_ra];
   end

   always_comb begin
      if (rows_ff == '0) rows_use = DIM_W'(1);
      else if (rows_ff > DIM_W'(MAX_ROWS)) rows_use = DIM_W'(MAX_ROWS);
      else rows_use = rows_ff;
      if (cols_ff == '0) cols_use = DIM_W'(1);
      else if (cols_ff > DIM_W'(MAX_COLS)) cols_use = DIM_W'(MAX_COLS);
      else cols_use = cols_ff;
   end

   assign start_cell = {sr_ff, sc_ff};
   assign goal_cell  = {gr_ff, gc_ff};
   assign cur_r      = cur_ff[NODE_W-1:COORD_W];
   assign cur_c      = cur_ff[COORD_W-1:0];

   always_comb begin
      nb_r   = cur_r;
      nb_c   = cur_c;
      nb_out = 1'b0;
      case (dir_ff)
         DIR_UP: begin
            nb_r   = cur_r - 1'b1;
            nb_out = (cur_r == '0);
         end
         DIR_DOWN: begin
            nb_r   = cur_r + 1'b1;
            nb_out = (DIM_W'(cur_r) + 1'b1) >= rows_use;
         end
         DIR_LEFT: begin
            nb_c   = cur_c - 1'b1;
            nb_out = (cur_c == '0);
         end
         default: begin
            nb_c   = cur_c + 1'b1;
            nb_out = (DIM_W'(cur_c) + 1'b1) >= cols_use;
         end
      endcase
   end

   assign nb_node = {nb_r, nb_c};
   assign ng      = cur_g_ff + 1'b1;

   always_comb begin
      new_entry.f     = ng + COST_W'(manhattan(nb_r, nb_c, gr_ff, gc_ff));
      new_entry.g     = ng;
      new_entry.node  = nb_node;
      new_entry.seq   = seq_ff;
      seed_entry.f    = COST_W'(manhattan(sr_ff, sc_ff, gr_ff, gc_ff));
      seed_entry.g    = '0;
      seed_entry.node = start_cell;
      seed_entry.seq  = '0;
   end

   assign l_idx   = {i_ff, 1'b1};
   assign r_idx   = l_idx + 1'b1;
   assign cnt_x   = HX_W'(count_ff);
   assign par_idx = HIDX_W'((i_ff - 1'b1) >> 1);

   // Sift-down choice: the moving entry against the left and right children.
   always_comb begin
      sd_best = mov_ff;
      sd_pick = i_ff;
      sd_stop = 1'b1;
      if (heap_less(left_ff, mov_ff)) begin
         sd_best = left_ff;
         sd_pick = l_idx[HIDX_W-1:0];
         sd_stop = 1'b0;
      end
      if (has_r_ff && heap_less(heap_q, sd_best)) begin
         sd_best = heap_q;
         sd_pick = r_idx[HIDX_W-1:0];
         sd_stop = 1'b0;
      end
   end

   // The path is stored goal first, so a read counts back from the end.
   assign rd_addr = len_ff - 1'b1 - LEN_W'(path_index);

   always_comb begin
      status.req_kind       = req_type;
      status.sweep_last     = (sweep_ff == NODE_W'(CELLS - 1));
      status.search_oob     = (DIM_W'(sr_ff) >= rows_use) || (DIM_W'(sc_ff) >= cols_use) ||
                              (DIM_W'(gr_ff) >= rows_use) || (DIM_W'(gc_ff) >= cols_use);
      status.search_trivial = (start_cell == goal_cell);
      status.heap_empty     = (count_ff == '0);
      status.pop_last       = (count_ff == HCNT_W'(1));
      status.sd_leaf        = (l_idx >= cnt_x);
      status.sd_stop        = sd_stop;
      status.cur_is_goal    = (cur_ff == goal_cell);
      status.cur_closed     = rec_q.closed;
      status.nb_out         = nb_out;
      status.nb_skip        = obs_q || rec_q.closed || (ng >= rec_q.best);
      status.heap_full      = (count_ff >= HCNT_W'(OPEN_DEPTH));
      status.su_root        = (i_ff == '0);
      status.su_stop        = !heap_less(mov_ff, heap_q);
      status.dir_last       = (dir_ff == DIR_RIGHT);
      status.path_over      = (n_ff >= LEN_W'(CELLS));
      status.path_end       = (par_q == start_cell);
   end

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      sr_in    = sr_ff;
      sc_in    = sc_ff;
      gr_in    = gr_ff;
      gc_in    = gc_ff;
      rd_ok_in = rd_ok_ff;
      found_in = found_ff;
      len_in   = len_ff;
      count_in = count_ff;
      seq_in   = seq_ff;
      sweep_in = sweep_ff;
      i_in     = i_ff;
      mov_in   = mov_ff;
      left_in  = left_ff;
      has_r_in = has_r_ff;
      cur_g_in = cur_g_ff;
      cur_in   = cur_ff;
      dir_in   = dir_ff;
      n_in     = n_ff;
      walk_in  = walk_ff;
      prow_in  = prow_ff;
      pcol_in  = pcol_ff;
      pval_in  = pval_ff;

      obs_we   = 1'b0;
      obs_wa   = sweep_ff;
      obs_wd   = 1'b0;
      obs_ra   = nb_node;
      rec_we   = 1'b0;
      rec_wa   = sweep_ff;
      rec_wd   = '{closed: 1'b0, best: COST_MAX};
      rec_ra   = nb_node;
      par_we   = 1'b0;
      par_wa   = nb_node;
      par_wd   = cur_ff;
      par_ra   = walk_ff;
      rpath_we = 1'b0;
      rpath_wa = '0;
      rpath_wd = goal_cell;
      rpath_ra = rd_addr[NODE_W-1:0];
      heap_we  = 1'b0;
      heap_wa  = i_ff;
      heap_wd  = mov_ff;
      heap_ra  = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_GRID_ROWS: rows_in = csr_data;
            CSR_GRID_COLS: cols_in = csr_data;
            default: ;
         endcase
      end

      case (cmd)
         CMD_MAP_CLEAR: begin
            obs_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
         end
         CMD_ACCEPT: begin
            sr_in    = start_row;
            sc_in    = start_col;
            gr_in    = goal_row;
            gc_in    = goal_col;
            prow_in  = '0;
            pcol_in  = '0;
            pval_in  = 1'b0;
            rd_ok_in = (LEN_W'(path_index) < len_ff);
            if (req_type == REQ_LOAD) begin
               obs_we = 1'b1;
               obs_wa = {cell_row, cell_col};
               obs_wd = blocked;
            end
         end
         CMD_READ_DONE: begin
            if (rd_ok_ff) begin
               prow_in = rpath_q[NODE_W-1:COORD_W];
               pcol_in = rpath_q[COORD_W-1:0];
               pval_in = 1'b1;
            end
         end
         CMD_SEARCH: begin
            found_in = 1'b0;
            len_in   = '0;
            count_in = '0;
            if (!status.search_oob && status.search_trivial) begin
               rpath_we = 1'b1;
               rpath_wd = start_cell;
               len_in   = LEN_W'(1);
               found_in = 1'b1;
            end
         end
         CMD_REC_CLEAR: begin
            rec_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
         end
         CMD_SEED: begin
            rec_we   = 1'b1;
            rec_wa   = start_cell;
            rec_wd   = '{closed: 1'b0, best: '0};
            heap_we  = 1'b1;
            heap_wa  = '0;
            heap_wd  = seed_entry;
            count_in = HCNT_W'(1);
            seq_in   = SEQ_W'(1);
         end
         CMD_POP_READ: begin
            heap_ra = '0;
         end
         CMD_POP_TAKE: begin
            cur_g_in = heap_q.g;
            cur_in   = heap_q.node;
            count_in = count_ff - 1'b1;
            heap_ra  = HIDX_W'(count_ff - 1'b1);
         end
         CMD_POP_LAST: begin
            mov_in = heap_q;
            i_in   = '0;
         end
         CMD_SD_LEFT: begin
            if (status.sd_leaf) heap_we = 1'b1;
            heap_ra = l_idx[HIDX_W-1:0];
         end
         CMD_SD_RIGHT: begin
            left_in  = heap_q;
            has_r_in = (r_idx < cnt_x);
            heap_ra  = r_idx[HIDX_W-1:0];
         end
         CMD_SD_CMP: begin
            heap_we = 1'b1;
            if (!sd_stop) begin
               heap_wd = sd_best;
               i_in    = sd_pick;
            end
         end
         CMD_EVAL: begin
            rec_ra = cur_ff;
         end
         CMD_CLOSE: begin
            if (!rec_q.closed) begin
               rec_we = 1'b1;
               rec_wa = cur_ff;
               rec_wd = '{closed: 1'b1, best: rec_q.best};
            end
            dir_in = DIR_UP;
         end
         CMD_NB_READ: begin
            obs_ra = nb_node;
            rec_ra = nb_node;
         end
         CMD_NB_RELAX: begin
            if (!status.nb_skip) begin
               rec_we = 1'b1;
               rec_wa = nb_node;
               rec_wd = '{closed: 1'b0, best: ng};
               par_we = 1'b1;
            end
         end
         CMD_PUSH: begin
            if (!status.heap_full) begin
               i_in     = HIDX_W'(count_ff);
               count_in = count_ff + 1'b1;
               mov_in   = new_entry;
               seq_in   = seq_ff + 1'b1;
            end
         end
         CMD_SU_READ: begin
            if (status.su_root) begin
               heap_we = 1'b1;
               heap_wa = '0;
            end
            heap_ra = par_idx;
         end
         CMD_SU_CMP: begin
            heap_we = 1'b1;
            if (!status.su_stop) begin
               heap_wd = heap_q;
               i_in    = par_idx;
            end
         end
         CMD_NB_NEXT: begin
            dir_in = dir_type'(dir_ff + 1'b1);
         end
         CMD_PATH_START: begin
            rpath_we = 1'b1;
            rpath_wa = '0;
            rpath_wd = goal_cell;
            n_in     = LEN_W'(1);
            walk_in  = goal_cell;
         end
         CMD_PT_READ: begin
            par_ra = walk_ff;
         end
         CMD_PT_STEP: begin
            rpath_we = 1'b1;
            rpath_wa = n_ff[NODE_W-1:0];
            rpath_wd = par_q;
            n_in     = n_ff + 1'b1;
            walk_in  = par_q;
            if (status.path_end) begin
               found_in = 1'b1;
               len_in   = n_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(MAX_ROWS);
         cols_ff  <= DIM_W'(MAX_COLS);
         rd_ok_ff <= 1'b0;
         found_ff <= 1'b0;
         len_ff   <= '0;
         count_ff <= '0;
         seq_ff   <= '0;
         sweep_ff <= '0;
         has_r_ff <= 1'b0;
         dir_ff   <= DIR_UP;
         n_ff     <= '0;
         i_ff     <= '0;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         rd_ok_ff <= rd_ok_in;
         found_ff <= found_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         sweep_ff <= sweep_in;
         has_r_ff <= has_r_in;
         dir_ff   <= dir_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff    <= sr_in;
      sc_ff    <= sc_in;
      gr_ff    <= gr_in;
      gc_ff    <= gc_in;
      mov_ff   <= mov_in;
      left_ff  <= left_in;
      cur_g_ff <= cur_g_in;
      cur_ff   <= cur_in;
      walk_ff  <= walk_in;
      prow_ff  <= prow_in;
      pcol_ff  <= pcol_in;
      pval_ff  <= pval_in;
   end

   assign found       = found_ff;
   assign path_length = len_ff;
   assign path_row    = prow_ff;
   assign path_col    = pcol_ff;
   assign index_valid = pval_ff;

endmodule

// ===== sv/grid_astar_path_search_top.sv =====
// Load, search and path read transactions are taken one transaction at a time.
// A search first does its setup and clears the per-cell records, then for each
// pop runs a sift-down over the heap levels, for each neighbor pushed a sift-up,
// and at the end walks the path cell by cell; the heap reads one entry a cycle.
// Reset is synchronous; afterwards a pass over every cell clears the obstacle map
// before the first request transaction is taken.
module grid_astar_path_search_top #(
   parameter int OPEN_DEPTH = 4096
) (
   input logic         clock,
   input logic         reset,
   gaps_req_if.sink    req_bus,
   gaps_rsp_if.source  rsp_bus,
   gaps_csr_if.sink    csr_bus
);
   import gaps_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   gaps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   gaps_dpath #(
      .OPEN_DEPTH (OPEN_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_bus.req_type),
      .cell_row    (req_bus.cell_row),
      .cell_col    (req_bus.cell_col),
      .blocked     (req_bus.blocked),
      .start_row   (req_bus.start_row),
      .start_col   (req_bus.start_col),
      .goal_row    (req_bus.goal_row),
      .goal_col    (req_bus.goal_col),
      .path_index  (req_bus.path_index),
      .csr_valid   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .found       (rsp_bus.found),
      .path_length (rsp_bus.path_length),
      .path_row    (rsp_bus.path_row),
      .path_col    (rsp_bus.path_col),
      .index_valid (rsp_bus.index_valid)
   );

endmodule

// ===== bench/grid_astar_path_search_top_tb.sv =====
module grid_astar_path_search_top_tb;
   import gaps_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int OPEN_LIMIT = 4096;
   localparam int CYCLE_LIMIT = 40000000;
   localparam int STEP_DR[4] = '{-1, 1, 0, 0};
   localparam int STEP_DC[4] = '{0, 0, -1, 1};

   typedef struct {
      logic [1:0]         kind;
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic               blocked;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] goal_row;
      logic [COORD_W-1:0] goal_col;
      logic [NODE_W-1:0]  path_index;
   } path_req_type;

   typedef struct {
      logic               found;
      logic [LEN_W-1:0]   path_length;
      logic [COORD_W-1:0] path_row;
      logic [COORD_W-1:0] path_col;
      logic               index_valid;
   } path_rsp_type;

   logic clock;
   logic reset;

   gaps_req_if req_bus();
   gaps_rsp_if rsp_bus();
   gaps_csr_if csr_bus();

   grid_astar_path_search_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state.
   logic [DIM_W-1:0] cfg_rows;
   logic [DIM_W-1:0] cfg_cols;
   bit               obstacle_bits[CELLS];
   bit               closed_mark[CELLS];
   int unsigned      best_g[CELLS];
   int unsigned      parent_node[CELLS];
   int unsigned      path_nodes[CELLS];
   int unsigned      path_len;
   bit               path_found;
   int unsigned      open_f[OPEN_LIMIT];
   int unsigned      open_g[OPEN_LIMIT];
   int unsigned      open_node[OPEN_LIMIT];
   int unsigned      open_seq[OPEN_LIMIT];
   int unsigned      open_count;
   int unsigned      open_next_seq;

   path_rsp_type expected_results[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   int        req_idle_pct;
   int        rsp_idle_pct;
   int        n_loads, n_searches, n_found, n_reads, n_hits;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL grid_astar_path_search_top");
         $finish;
      end
   end

   function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] raw, input int hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic int unsigned coord_gap(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic bit open_less(input int unsigned i, input int unsigned j);
      if (open_f[i] != open_f[j]) return open_f[i] < open_f[j];
      return open_seq[i] < open_seq[j];
   endfunction

   function automatic void open_swap(input int unsigned i, input int unsigned j);
      int unsigned t;
      t = open_f[i];    open_f[i] = open_f[j];       open_f[j] = t;
      t = open_g[i];    open_g[i] = open_g[j];       open_g[j] = t;
      t = open_node[i]; open_node[i] = open_node[j]; open_node[j] = t;
      t = open_seq[i];  open_seq[i] = open_seq[j];   open_seq[j] = t;
   endfunction

   function automatic bit open_push(input int unsigned f, input int unsigned g,
                                    input int unsigned node);
      int unsigned i, p;
      if (open_count >= OPEN_LIMIT) return 0;
      i = open_count;
      open_count++;
      open_f[i] = f;
      open_g[i] = g;
      open_node[i] = node;
      open_seq[i] = open_next_seq;
      open_next_seq++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!open_less(i, p)) break;
         open_swap(i, p);
         i = p;
      end
      return 1;
   endfunction

   function automatic void open_pop(output int unsigned g, output int unsigned node);
      int unsigned i, l, r, m;
      g = open_g[0];
      node = open_node[0];
      open_count--;
      if (open_count == 0) return;
      open_swap(0, open_count);
      i = 0;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         m = i;
         if (l < open_count && open_less(l, m)) m = l;
         if (r < open_count && open_less(r, m)) m = r;
         if (m == i) break;
         open_swap(i, m);
         i = m;
      end
   endfunction

   function automatic void run_path_search(input int unsigned sr, input int unsigned sc,
                                           input int unsigned gr, input int unsigned gc);
      int unsigned rows, cols, start_n, goal_n, g, cur, cr, cc, nb, ng, n, c, t;
      int nr, nc;
      bit reached;
      rows = dim_in_use(cfg_rows, MAX_ROWS);
      cols = dim_in_use(cfg_cols, MAX_COLS);
      path_found = 0;
      path_len = 0;
      open_count = 0;
      open_next_seq = 0;
      reached = 0;
      if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return;
      start_n = sr * MAX_COLS + sc;
      goal_n = gr * MAX_COLS + gc;
      if (start_n == goal_n) begin
         path_nodes[0] = start_n;
         path_len = 1;
         path_found = 1;
         return;
      end
      for (int k = 0; k < CELLS; k++) begin
         closed_mark[k] = 0;
         best_g[k] = '1;
      end
      best_g[start_n] = 0;
      void'(open_push(coord_gap(sr, gr) + coord_gap(sc, gc), 0, start_n));
      while (open_count > 0) begin
         open_pop(g, cur);
         if (cur == goal_n) begin
            reached = 1;
            break;
         end
         if (closed_mark[cur]) continue;
         closed_mark[cur] = 1;
         cr = cur / MAX_COLS;
         cc = cur % MAX_COLS;
         for (int d = 0; d < 4; d++) begin
            nr = int'(cr) + STEP_DR[d];
            nc = int'(cc) + STEP_DC[d];
            if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
            nb = nr * MAX_COLS + nc;
            if (obstacle_bits[nb] || closed_mark[nb]) continue;
            ng = g + 1;
            if (ng >= best_g[nb]) continue;
            best_g[nb] = ng;
            parent_node[nb] = cur;
            if (!open_push(ng + coord_gap(nr, gr) + coord_gap(nc, gc), ng, nb)) begin
               open_count = 0;
               return;
            end
         end
      end
      open_count = 0;
      if (!reached) return;
      n = 0;
      c = goal_n;
      path_nodes[n++] = c;
      forever begin
         if (n >= CELLS) return;
         c = parent_node[c] % CELLS;
         path_nodes[n++] = c;
         if (c == start_n) break;
      end
      for (int k = 0; k < n / 2; k++) begin
         t = path_nodes[k];
         path_nodes[k] = path_nodes[n - 1 - k];
         path_nodes[n - 1 - k] = t;
      end
      path_len = n;
      path_found = 1;
   endfunction

   // Updates the predictor with one accepted transaction and queues its result.
   function automatic void apply_request(input path_req_type r);
      path_rsp_type e;
      e.path_row = '0;
      e.path_col = '0;
      e.index_valid = 1'b0;
      case (r.kind)
         REQ_LOAD: begin
            obstacle_bits[r.cell_row * MAX_COLS + r.cell_col] = r.blocked;
            n_loads++;
         end
         REQ_SEARCH: begin
            run_path_search(r.start_row, r.start_col, r.goal_row, r.goal_col);
            n_searches++;
            if (path_found) n_found++;
         end
         REQ_READ: begin
            n_reads++;
            if (r.path_index < path_len) begin
               e.path_row = COORD_W'(path_nodes[r.path_index] / MAX_COLS);
               e.path_col = COORD_W'(path_nodes[r.path_index] % MAX_COLS);
               e.index_valid = 1'b1;
               n_hits++;
            end
         end
         default: ;
      endcase
      e.found = path_found;
      e.path_length = LEN_W'(path_len);
      expected_results = {expected_results, e};
   endfunction

   always @(posedge clock) begin
      path_rsp_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expectation pending");
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_bus.found !== e.found) begin
                  $error("found: expected %0d, actual %0d", e.found, rsp_bus.found);
                  fail_count++;
               end
               if (rsp_bus.path_length !== e.path_length) begin
                  $error("path_length: expected %0d, actual %0d", e.path_length,
                         rsp_bus.path_length);
                  fail_count++;
               end
               if (rsp_bus.path_row !== e.path_row) begin
                  $error("path_row: expected %0d, actual %0d", e.path_row, rsp_bus.path_row);
                  fail_count++;
               end
               if (rsp_bus.path_col !== e.path_col) begin
                  $error("path_col: expected %0d, actual %0d", e.path_col, rsp_bus.path_col);
                  fail_count++;
               end
               if (rsp_bus.index_valid !== e.index_valid) begin
                  $error("index_valid: expected %0d, actual %0d", e.index_valid,
                         rsp_bus.index_valid);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_request(input path_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= r.kind;
      req_bus.cell_row   <= r.cell_row;
      req_bus.cell_col   <= r.cell_col;
      req_bus.blocked    <= r.blocked;
      req_bus.start_row  <= r.start_row;
      req_bus.start_col  <= r.start_col;
      req_bus.goal_row   <= r.goal_row;
      req_bus.goal_col   <= r.goal_col;
      req_bus.path_index <= r.path_index;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_request(r);
   endtask

   // Holds the request channel idle until every pending result has arrived.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_grid_size(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_GRID_ROWS;
      csr_bus.data  <= rows;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      cfg_rows = rows;
      csr_bus.index <= CSR_GRID_COLS;
      csr_bus.data  <= cols;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      cfg_cols = cols;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic path_req_type blank_request(input logic [1:0] kind);
      path_req_type r;
      r.kind = kind;
      r.cell_row = COORD_W'($urandom);
      r.cell_col = COORD_W'($urandom);
      r.blocked = 1'($urandom);
      r.start_row = COORD_W'($urandom);
      r.start_col = COORD_W'($urandom);
      r.goal_row = COORD_W'($urandom);
      r.goal_col = COORD_W'($urandom);
      r.path_index = NODE_W'($urandom);
      return r;
   endfunction

   function automatic path_req_type load_request(input int row, input int col, input bit blk);
      path_req_type r;
      r = blank_request(REQ_LOAD);
      r.cell_row = COORD_W'(row);
      r.cell_col = COORD_W'(col);
      r.blocked = blk;
      return r;
   endfunction

   function automatic path_req_type search_request(input int sr, input int sc,
                                                   input int gr, input int gc);
      path_req_type r;
      r = blank_request(REQ_SEARCH);
      r.start_row = COORD_W'(sr);
      r.start_col = COORD_W'(sc);
      r.goal_row = COORD_W'(gr);
      r.goal_col = COORD_W'(gc);
      return r;
   endfunction

   function automatic path_req_type read_request(input int idx);
      path_req_type r;
      r = blank_request(REQ_READ);
      r.path_index = NODE_W'(idx);
      return r;
   endfunction

   // Coordinate mostly inside the grid in use, sometimes anywhere in the map.
   function automatic int pick_coord(input int unsigned span, input int inside_pct);
      if ($urandom_range(99) < inside_pct) return $urandom_range(span - 1);
      return $urandom_range(31);
   endfunction

   function automatic path_req_type random_request();
      int unsigned rows, cols, pick;
      rows = dim_in_use(cfg_rows, MAX_ROWS);
      cols = dim_in_use(cfg_cols, MAX_COLS);
      pick = $urandom_range(99);
      if (pick < 45)
         return load_request(pick_coord(rows, 85), pick_coord(cols, 85),
                             $urandom_range(99) < 30);
      if (pick < 68)
         return search_request(pick_coord(rows, 92), pick_coord(cols, 92),
                               pick_coord(rows, 92), pick_coord(cols, 92));
      if (pick < 98) begin
         if ($urandom_range(99) < 75)
            return read_request($urandom_range(path_len > 1023 ? 1023 : path_len));
         return read_request($urandom_range(1023));
      end
      return blank_request(REQ_UNUSED);
   endfunction

   task automatic test_directed();
      write_grid_size(6'd32, 6'd32);
      send_request(read_request(0));
      send_request(blank_request(REQ_UNUSED));
      send_request(search_request(5, 7, 5, 7));
      send_request(read_request(0));
      send_request(read_request(1));
      send_request(load_request(31, 31, 1));
      send_request(load_request(0, 0, 1));
      // The start is expanded even when it is an obstacle.
      send_request(search_request(0, 0, 0, 3));
      send_request(read_request(3));
      send_request(read_request(1023));
      // A blocked goal is never reached.
      send_request(search_request(30, 31, 31, 31));
      send_request(load_request(31, 31, 0));
      send_request(load_request(0, 0, 0));
      send_request(search_request(0, 0, 31, 31));
      send_request(read_request(62));
      send_request(read_request(63));
      drain_results();
      // Out-of-range register values saturate; start or goal outside is not found.
      write_grid_size(6'd0, 6'd63);
      send_request(search_request(1, 0, 0, 0));
      send_request(search_request(0, 0, 0, 31));
      send_request(read_request(31));
      send_request(read_request(32));
      send_request(search_request(0, 31, 0, 31));
      write_grid_size(6'd63, 6'd0);
      send_request(search_request(31, 0, 0, 1));
      send_request(search_request(31, 0, 0, 0));
   endtask

   task automatic test_random(input int req_pct, input int rsp_pct);
      logic [DIM_W-1:0] size_list[8][2];
      int count;
      size_list = '{'{6'd4, 6'd4}, '{6'd8, 6'd5}, '{6'd1, 6'd7}, '{6'd6, 6'd1},
                    '{6'd0, 6'd63}, '{6'd63, 6'd3}, '{6'd8, 6'd8}, '{6'd32, 6'd32}};
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      for (int s = 0; s < 8; s++) begin
         write_grid_size(size_list[s][0], size_list[s][1]);
         // Searches on the full grid are slow, so that setting gets few transactions.
         count = (s == 7) ? 12 : 30;
         for (int i = 0; i < count; i++) begin
            send_request(random_request());
            if (s == 3 && i == 15) drain_results();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      n_loads = 0; n_searches = 0; n_found = 0; n_reads = 0; n_hits = 0;
      cfg_rows = 6'd32;
      cfg_cols = 6'd32;
      path_len = 0;
      path_found = 0;
      for (int k = 0; k < CELLS; k++) begin
         obstacle_bits[k] = 0;
         path_nodes[k] = 0;
         parent_node[k] = 0;
      end
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_LOAD;
      req_bus.cell_row   <= '0;
      req_bus.cell_col   <= '0;
      req_bus.blocked    <= 1'b0;
      req_bus.start_row  <= '0;
      req_bus.start_col  <= '0;
      req_bus.goal_row   <= '0;
      req_bus.goal_col   <= '0;
      req_bus.path_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= CSR_GRID_ROWS;
      csr_bus.data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(34, 74);
      test_random(74, 34);
      test_random(0, 0);

      drain_results();
      repeat (50) @(posedge clock);
      $display("Covered %0d loads, %0d searches (%0d found), %0d path reads (%0d in range).",
               n_loads, n_searches, n_found, n_reads, n_hits);
      $display("Grid sizes from one row or column up to the full map, with saturation.");
      if (fail_count == 0) begin
         $display("PASS grid_astar_path_search_top");
      end else begin
         $display("FAIL grid_astar_path_search_top");
      end
      $finish;
   end

endmodule

// ===== grid_astar_path_search_top.f =====
sv/gaps_pkg.sv
sv/gaps_if.sv
sv/gaps_ctrl.sv
sv/gaps_dpath.sv
sv/grid_astar_path_search_top.sv
bench/grid_astar_path_search_top_tb.sv
